### design/asbb_pkg.sv
// ----------------------------------------------------------------------------
// asbb_pkg
// shared types, widths and helpers for the span bounding box block
// ----------------------------------------------------------------------------
package asbb_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int RADIUS_WIDTH = COORD_WIDTH - 1;

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // quadrant codes, also the index of the axis extreme that follows them
  localparam logic [1:0] QUAD_TOP    = 2'd0;
  localparam logic [1:0] QUAD_LEFT   = 2'd1;
  localparam logic [1:0] QUAD_BOTTOM = 2'd2;
  localparam logic [1:0] QUAD_RIGHT  = 2'd3;

  typedef logic [COORD_WIDTH-1:0]  coord_t;
  typedef logic [RADIUS_WIDTH-1:0] radius_t;

  // one span as taken from the input ports
  typedef struct packed {
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    logic    is_arc;
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius;
    logic    sweep_positive;
  } span_t;

  // circle extremes that join the box, with their saturated coordinates
  typedef struct packed {
    logic [3:0] incl;
    coord_t     top_y;
    coord_t     left_x;
    coord_t     bottom_y;
    coord_t     right_x;
  } ext_t;

  function automatic coord_t coord_min(input coord_t a, input coord_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic coord_t coord_max(input coord_t a, input coord_t b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

### design/asbb_extremes.sv
// ----------------------------------------------------------------------------
// asbb_extremes
// quadrant classification, swept extreme selection and saturated extremes
// ----------------------------------------------------------------------------
module asbb_extremes (
  input  asbb_pkg::span_t span,
  output asbb_pkg::ext_t  ext
);

  localparam int W = asbb_pkg::COORD_WIDTH;

  logic       s_gx, s_gy, e_gx, e_gy;
  logic [1:0] q_start, q_end, qs, qe, span_len;
  logic [W:0] cy_add, cx_sub, cy_sub, cx_add;
  logic [W:0] r_ext;

  function automatic logic [1:0] quad(input logic gx, input logic gy);
    logic [1:0] q;
    if (gx) begin
      q = gy ? asbb_pkg::QUAD_TOP : asbb_pkg::QUAD_RIGHT;
    end else begin
      q = gy ? asbb_pkg::QUAD_LEFT : asbb_pkg::QUAD_BOTTOM;
    end
    return q;
  endfunction

  always_comb begin
    s_gx = $signed(span.start_x) > $signed(span.center_x);
    s_gy = $signed(span.start_y) > $signed(span.center_y);
    e_gx = $signed(span.end_x)   > $signed(span.center_x);
    e_gy = $signed(span.end_y)   > $signed(span.center_y);
    q_start = quad(s_gx, s_gy);
    q_end   = quad(e_gx, e_gy);
    qs = span.sweep_positive ? q_end : q_start;
    qe = span.sweep_positive ? q_start : q_end;
    // quadrants crossed, modulo four; equal quadrants cross none
    span_len = qe - qs;
    for (int k = 0; k < 4; k++) begin
      ext.incl[k] = span.is_arc && ((2'(k) - qs) < span_len);
    end
  end

  // centre plus or minus radius, one guard bit, clamp on overflow
  always_comb begin
    r_ext  = {2'b00, span.radius};
    cy_add = {span.center_y[W-1], span.center_y} + r_ext;
    cx_add = {span.center_x[W-1], span.center_x} + r_ext;
    cy_sub = {span.center_y[W-1], span.center_y} - r_ext;
    cx_sub = {span.center_x[W-1], span.center_x} - r_ext;
    ext.top_y    = (cy_add[W] != cy_add[W-1]) ? asbb_pkg::COORD_MAX : cy_add[W-1:0];
    ext.right_x  = (cx_add[W] != cx_add[W-1]) ? asbb_pkg::COORD_MAX : cx_add[W-1:0];
    ext.bottom_y = (cy_sub[W] != cy_sub[W-1]) ? asbb_pkg::COORD_MIN : cy_sub[W-1:0];
    ext.left_x   = (cx_sub[W] != cx_sub[W-1]) ? asbb_pkg::COORD_MIN : cx_sub[W-1:0];
  end

endmodule

### design/arc_span_bounding_box_top.sv
// ----------------------------------------------------------------------------
// arc_span_bounding_box_top
// axis-aligned bounding box of a line or circular arc span, one span a cycle
// ----------------------------------------------------------------------------
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  input   | in_* span fields               | word taken when start & !busy
//  result  | out_min_x/y, out_max_x/y       | out_valid strobe, one cycle
//
//  - one span accepted every cycle; busy is tied low
//  - each span passes the span register, then the box register
//  - the compare / saturating add / min-max path between the two sets the clock
//  - rst_n (synchronous) clears the valid flags only, payload is not reset
//  - the receiver cannot stall, so nothing ever backs up
//
module arc_span_bounding_box_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_start_x,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_start_y,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_end_x,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_end_y,
  input  logic                                in_is_arc,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_center_x,
  input  logic signed [asbb_pkg::COORD_WIDTH-1:0]  in_center_y,
  input  logic        [asbb_pkg::RADIUS_WIDTH-1:0] in_radius,
  input  logic                                in_sweep_positive,
  output logic                                out_valid,
  output logic signed [asbb_pkg::COORD_WIDTH-1:0]  out_min_x,
  output logic signed [asbb_pkg::COORD_WIDTH-1:0]  out_min_y,
  output logic signed [asbb_pkg::COORD_WIDTH-1:0]  out_max_x,
  output logic signed [asbb_pkg::COORD_WIDTH-1:0]  out_max_y
);

  // span register
  logic            span_vld_r;
  asbb_pkg::span_t span_r;
  asbb_pkg::ext_t  ext;

  // box register
  logic             box_vld_r;
  asbb_pkg::coord_t min_x_r, min_y_r, max_x_r, max_y_r;
  asbb_pkg::coord_t min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;

  // never refuses a word
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_vld_r <= 1'b0;
      box_vld_r  <= 1'b0;
    end else begin
      span_vld_r <= start && !busy;
      box_vld_r  <= span_vld_r;
    end
  end

  // capture the span on accept
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      span_r.start_x        <= in_start_x;
      span_r.start_y        <= in_start_y;
      span_r.end_x          <= in_end_x;
      span_r.end_y          <= in_end_y;
      span_r.is_arc         <= in_is_arc;
      span_r.center_x       <= in_center_x;
      span_r.center_y       <= in_center_y;
      span_r.radius         <= in_radius;
      span_r.sweep_positive <= in_sweep_positive;
    end
  end

  // which circle extremes the arc sweeps over, and where they sit
  asbb_extremes u_extremes (
    .span (span_r),
    .ext  (ext)
  );

  // box over the end points plus the selected extremes
  always_comb begin
    min_x_nxt = asbb_pkg::coord_min(span_r.start_x, span_r.end_x);
    max_x_nxt = asbb_pkg::coord_max(span_r.start_x, span_r.end_x);
    min_y_nxt = asbb_pkg::coord_min(span_r.start_y, span_r.end_y);
    max_y_nxt = asbb_pkg::coord_max(span_r.start_y, span_r.end_y);

    // top and bottom points sit at the centre x
    if (ext.incl[asbb_pkg::QUAD_TOP] || ext.incl[asbb_pkg::QUAD_BOTTOM]) begin
      min_x_nxt = asbb_pkg::coord_min(min_x_nxt, span_r.center_x);
      max_x_nxt = asbb_pkg::coord_max(max_x_nxt, span_r.center_x);
    end
    // left and right points sit at the centre y
    if (ext.incl[asbb_pkg::QUAD_LEFT] || ext.incl[asbb_pkg::QUAD_RIGHT]) begin
      min_y_nxt = asbb_pkg::coord_min(min_y_nxt, span_r.center_y);
      max_y_nxt = asbb_pkg::coord_max(max_y_nxt, span_r.center_y);
    end
    // end points need not lie on the circle, so an extreme can land on
    // either side of them
    if (ext.incl[asbb_pkg::QUAD_TOP]) begin
      min_y_nxt = asbb_pkg::coord_min(min_y_nxt, ext.top_y);
      max_y_nxt = asbb_pkg::coord_max(max_y_nxt, ext.top_y);
    end
    if (ext.incl[asbb_pkg::QUAD_LEFT]) begin
      min_x_nxt = asbb_pkg::coord_min(min_x_nxt, ext.left_x);
      max_x_nxt = asbb_pkg::coord_max(max_x_nxt, ext.left_x);
    end
    if (ext.incl[asbb_pkg::QUAD_BOTTOM]) begin
      min_y_nxt = asbb_pkg::coord_min(min_y_nxt, ext.bottom_y);
      max_y_nxt = asbb_pkg::coord_max(max_y_nxt, ext.bottom_y);
    end
    if (ext.incl[asbb_pkg::QUAD_RIGHT]) begin
      min_x_nxt = asbb_pkg::coord_min(min_x_nxt, ext.right_x);
      max_x_nxt = asbb_pkg::coord_max(max_x_nxt, ext.right_x);
    end
  end

  always_ff @(posedge clk) begin
    if (span_vld_r) begin
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  assign out_valid = box_vld_r;
  assign out_min_x = min_x_r;
  assign out_min_y = min_y_r;
  assign out_max_x = max_x_r;
  assign out_max_y = max_y_r;

  // every accepted span gives a box, through the span register and then the box register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted span produced no box");

  // no box without a start that went through the span and box registers
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2))
    else $error("box strobe without an accepted span");

  // the box is never inverted, both end points are always inside it
  a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_min_x) <= $signed(out_max_x)))
    else $error("box x edges inverted");

  a_y_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_min_y) <= $signed(out_max_y)))
    else $error("box y edges inverted");

endmodule
